// ===== rtl/core/fcp_pkg.sv =====
// Package for the failover controller picker.
// Holds the table depth, widths, operation codes and the table port structs.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fcp_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int ADDR_W      = 48;
   localparam int PRIO_W      = 16;
   localparam int RPRIO_W     = 8;
   localparam int PENALTY_W   = 15;

   localparam int REQ_DATA_W  = 56;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 72;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [PENALTY_W-1:0] PENALTY_RESET = PENALTY_W'(200);
   localparam logic signed [PRIO_W-1:0] NO_PRIORITY = -PRIO_W'(1);
   localparam logic signed [PRIO_W:0] PRIO_MAX = (PRIO_W+1)'(32767);
   localparam logic signed [PRIO_W:0] PRIO_MIN = -(PRIO_W+1)'(32768);

   typedef enum logic [REQ_USER_W-1:0] {
      OP_START_ROUND    = 2'd0,
      OP_REPORT         = 2'd1,
      OP_PICK           = 2'd2,
      OP_CONNECT_FAILED = 2'd3
   } op_type;

   typedef struct packed {
      logic                     addr_en;
      logic                     prio_en;
      logic                     seen_en;
      logic [IDX_W-1:0]         index;
      logic [ADDR_W-1:0]        addr;
      logic signed [PRIO_W-1:0] prio;
      logic                     seen;
   } table_wr_type;

   typedef struct packed {
      logic [ADDR_W-1:0]        addr;
      logic signed [PRIO_W-1:0] prio;
      logic                     seen;
   } table_rd_type;

endpackage

// ===== rtl/core/fcp_regs.sv =====
// Configuration register file of the failover controller picker.
// Holds the penalty register behind an APB-style port; uses fcp_pkg.
`timescale 1ns / 1ps

module fcp_regs
   import fcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [PENALTY_W-1:0]  penalty
);

   logic [PENALTY_W-1:0] penalty_ff;
   logic [PENALTY_W-1:0] penalty_in;
   logic                 sel_penalty;

   assign sel_penalty = (csr_paddr[CSR_ADDR_W-1] == 1'b0);
   assign csr_pready  = 1'b1;
   assign penalty     = penalty_ff;
   assign csr_prdata  = sel_penalty ? CSR_DATA_W'(penalty_ff) : '0;

   always_comb begin
      penalty_in = penalty_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_penalty) begin
         penalty_in = csr_pwdata[PENALTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         penalty_ff <= PENALTY_RESET;
      end else begin
         penalty_ff <= penalty_in;
      end
   end

endmodule

// ===== rtl/core/fcp_table.sv =====
// Peer table of the failover controller picker.
// Address, priority and seen mark per entry, one read port and one write port; uses fcp_pkg.
`timescale 1ns / 1ps

module fcp_table
   import fcp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  rd_index,
   output table_rd_type      rd,
   input  table_wr_type      wr
);

   logic [ADDR_W-1:0]        addr_ff [TABLE_DEPTH];
   logic signed [PRIO_W-1:0] prio_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]   seen_ff;

   assign rd.addr = addr_ff[rd_index];
   assign rd.prio = prio_ff[rd_index];
   assign rd.seen = seen_ff[rd_index];

   always_ff @(posedge clock) begin
      if (wr.addr_en) begin
         addr_ff[wr.index] <= wr.addr;
      end
      if (wr.prio_en) begin
         prio_ff[wr.index] <= wr.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (wr.seen_en) begin
         seen_ff[wr.index] <= wr.seen;
      end
   end

endmodule

// ===== rtl/core/fcp_alu.sv =====
// Shared arithmetic unit of the failover controller picker.
// Saturating penalty add or subtract, priority compare and address match; uses fcp_pkg.
`timescale 1ns / 1ps

module fcp_alu
   import fcp_pkg::*;
(
   input  logic signed [PRIO_W-1:0] entry_prio,
   input  logic signed [PRIO_W-1:0] best,
   input  logic [PENALTY_W-1:0]     penalty,
   input  logic                     subtract,
   input  logic [ADDR_W-1:0]        entry_addr,
   input  logic [ADDR_W-1:0]        req_addr,
   output logic signed [PRIO_W-1:0] sum,
   output logic                     at_or_above,
   output logic                     nonnegative,
   output logic                     addr_match
);

   logic signed [PRIO_W:0] wide_prio;
   logic signed [PRIO_W:0] wide_pen;
   logic signed [PRIO_W:0] wide_sum;

   assign wide_prio = {entry_prio[PRIO_W-1], entry_prio};
   assign wide_pen  = {{(PRIO_W+1-PENALTY_W){1'b0}}, penalty};
   assign wide_sum  = subtract ? (wide_prio - wide_pen) : (wide_prio + wide_pen);

   always_comb begin
      priority if (wide_sum > PRIO_MAX) begin
         sum = PRIO_MAX[PRIO_W-1:0];
      end else if (wide_sum < PRIO_MIN) begin
         sum = PRIO_MIN[PRIO_W-1:0];
      end else begin
         sum = wide_sum[PRIO_W-1:0];
      end
   end

   assign at_or_above = (entry_prio >= best);
   assign nonnegative = ~entry_prio[PRIO_W-1];
   assign addr_match  = (entry_addr == req_addr);

endmodule

// ===== rtl/core/failover_controller_picker.sv =====
// A request is taken only while the sequencer is idle and then walks the peer table one entry
// per cycle through the single table read port and the shared saturating adder. A report stops
// at the first matching entry, and a pick walks the table twice, first to compact it and then
// to scan the kept entries; only a pick returns a response, held in an output register
// so the next request is accepted while it waits.
// Top level of the failover controller picker; uses fcp_pkg, fcp_regs, fcp_table and fcp_alu.
`timescale 1ns / 1ps

module failover_controller_picker
   import fcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata: peer_address[47:0], reported_priority[55:48].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: operation[1:0].
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: found[0], chosen_address[48:1], chosen_priority[64:49], overflow[65].
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_REPORT,
      ST_FAIL,
      ST_COMPACT,
      ST_SCAN,
      ST_DELIVER
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         kept_ff, kept_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     all_bad_ff, all_bad_in;
   logic                     overflow_ff, overflow_in;
   logic                     bad_acc_ff, bad_acc_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [RPRIO_W-1:0]       rprio_ff, rprio_in;
   logic signed [PRIO_W-1:0] best_ff, best_in;
   logic [ADDR_W-1:0]        chosen_ff, chosen_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic [PENALTY_W-1:0]     penalty;
   table_rd_type             rd;
   table_wr_type             wr;
   logic signed [PRIO_W-1:0] alu_sum;
   logic                     alu_ge;
   logic                     alu_nonneg;
   logic                     alu_match;
   logic                     in_range;
   logic                     req_accept;

   fcp_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .penalty     (penalty)
   );

   fcp_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_index (idx_ff[IDX_W-1:0]),
      .rd       (rd),
      .wr       (wr)
   );

   fcp_alu u_alu (
      .entry_prio  (rd.prio),
      .best        (best_ff),
      .penalty     (penalty),
      .subtract    (state_ff == ST_FAIL),
      .entry_addr  (rd.addr),
      .req_addr    (addr_ff),
      .sum         (alu_sum),
      .at_or_above (alu_ge),
      .nonnegative (alu_nonneg),
      .addr_match  (alu_match)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign in_range   = (idx_ff < count_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      kept_in      = kept_ff;
      count_in     = count_ff;
      all_bad_in   = all_bad_ff;
      overflow_in  = overflow_ff;
      bad_acc_in   = bad_acc_ff;
      addr_in      = addr_ff;
      rprio_in     = rprio_ff;
      best_in      = best_ff;
      chosen_in    = chosen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr           = '0;
      wr.index     = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               addr_in    = req_tdata[ADDR_W-1:0];
               rprio_in   = req_tdata[ADDR_W+RPRIO_W-1:ADDR_W];
               idx_in     = '0;
               kept_in    = '0;
               bad_acc_in = 1'b1;
               best_in    = NO_PRIORITY;
               chosen_in  = '0;
               unique case (op_type'(req_tuser))
                  OP_START_ROUND:    state_in = ST_START;
                  OP_REPORT:         state_in = ST_REPORT;
                  OP_PICK:           state_in = ST_COMPACT;
                  OP_CONNECT_FAILED: state_in = ST_FAIL;
               endcase
            end
         end
         ST_START: begin
            if (in_range) begin
               wr.seen_en = 1'b1;
               wr.seen    = 1'b0;
               if (alu_nonneg) begin
                  bad_acc_in = 1'b0;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               all_bad_in  = bad_acc_ff;
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (in_range) begin
               if (alu_match) begin
                  wr.seen_en = 1'b1;
                  wr.seen    = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  wr.addr_en = 1'b1;
                  wr.prio_en = 1'b1;
                  wr.seen_en = 1'b1;
                  wr.index   = count_ff[IDX_W-1:0];
                  wr.addr    = addr_ff;
                  wr.prio    = PRIO_W'(rprio_ff);
                  wr.seen    = 1'b1;
                  count_in   = count_ff + 1'b1;
                  all_bad_in = 1'b0;
               end else begin
                  overflow_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FAIL: begin
            if (in_range) begin
               if (alu_match) begin
                  wr.prio_en = 1'b1;
                  wr.prio    = alu_sum;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_COMPACT: begin
            if (in_range) begin
               if (rd.seen) begin
                  wr.addr_en = 1'b1;
                  wr.prio_en = 1'b1;
                  wr.seen_en = 1'b1;
                  wr.index   = kept_ff[IDX_W-1:0];
                  wr.addr    = rd.addr;
                  wr.prio    = rd.prio;
                  wr.seen    = 1'b1;
                  kept_in    = kept_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               count_in = kept_ff;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (in_range) begin
               if (alu_ge) begin
                  chosen_in = rd.addr;
                  best_in   = rd.prio;
               end else if (all_bad_ff) begin
                  wr.prio_en = 1'b1;
                  wr.prio    = alu_sum;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({overflow_ff, best_ff, chosen_ff,
                                           best_ff != NO_PRIORITY});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         kept_ff      <= '0;
         count_ff     <= '0;
         all_bad_ff   <= 1'b1;
         overflow_ff  <= 1'b0;
         bad_acc_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         kept_ff      <= kept_in;
         count_ff     <= count_in;
         all_bad_ff   <= all_bad_in;
         overflow_ff  <= overflow_in;
         bad_acc_ff   <= bad_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      rprio_ff    <= rprio_in;
      best_ff     <= best_in;
      chosen_ff   <= chosen_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/core/fcp_checker.sv =====
// Port-level checker for the failover controller picker, bound to the top level.
// Watches the request and response ports; uses fcp_pkg.
`timescale 1ns / 1ps

module fcp_checker
   import fcp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The found flag agrees with the reported priority.
   a_found_prio: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[64:49] != 16'hFFFF)))
      else $error("found flag disagrees with chosen priority");

   // An accepted request leaves the request port not ready, so requests are never taken back to back.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

   // Reset leaves no response pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

endmodule

bind failover_controller_picker fcp_checker u_fcp_checker (.*);

// ===== tb/tb_failover_controller_picker.sv =====
// Testbench for failover_controller_picker: directed and random request streams are checked
// against a predictor of the peer table that lives in a small scoreboard class.
// Depends on fcp_pkg and the failover_controller_picker RTL.
`timescale 1ns / 1ps

module tb_failover_controller_picker;
   import fcp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_PENALTY = '0;
   localparam int ITEM_GOAL = 1900;
   localparam int PHASES = 8;
   localparam int POOL_SIZE = 12;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic                     found;
      logic [ADDR_W-1:0]        addr;
      logic signed [PRIO_W-1:0] prio;
      logic                     overflow;
   } pick_result_type;

   class pick_scoreboard;
      logic [PENALTY_W-1:0]     penalty;
      int                       count;
      logic [ADDR_W-1:0]        addr_tab[TABLE_DEPTH];
      logic signed [PRIO_W-1:0] prio_tab[TABLE_DEPTH];
      bit                       seen_tab[TABLE_DEPTH];
      bit                       all_bad;
      bit                       overflow;
      pick_result_type          expected_picks[$];
      int                       errors;

      function new();
         penalty = PENALTY_RESET;
         count = 0;
         all_bad = 1'b1;
         overflow = 1'b0;
         errors = 0;
         foreach (seen_tab[i]) begin
            seen_tab[i] = 1'b0;
            addr_tab[i] = '0;
            prio_tab[i] = '0;
         end
      endfunction

      function logic signed [PRIO_W-1:0] saturate(int v);
         if (v > int'(PRIO_MAX)) return PRIO_W'(int'(PRIO_MAX));
         if (v < int'(PRIO_MIN)) return PRIO_W'(int'(PRIO_MIN));
         return PRIO_W'(v);
      endfunction

      function void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
         errors++;
         if (errors <= 10)
            $display("mismatch in %s: expected %h, got %h", field, want, got);
      endfunction

      function void note_request(op_type op, logic [ADDR_W-1:0] a, logic [RPRIO_W-1:0] rp);
         int                i;
         int                kept;
         int                best;
         bit                hit;
         logic [ADDR_W-1:0] chosen;
         pick_result_type   r;
         case (op)
            OP_START_ROUND: begin
               all_bad = 1'b1;
               for (i = 0; i < count; i++) begin
                  seen_tab[i] = 1'b0;
                  if (prio_tab[i] >= 0) all_bad = 1'b0;
               end
               overflow = 1'b0;
            end
            OP_REPORT: begin
               hit = 1'b0;
               for (i = 0; i < count; i++) begin
                  if (!hit && addr_tab[i] == a) begin
                     seen_tab[i] = 1'b1;
                     hit = 1'b1;
                  end
               end
               if (!hit) begin
                  if (count < TABLE_DEPTH) begin
                     addr_tab[count] = a;
                     prio_tab[count] = {{(PRIO_W-RPRIO_W){1'b0}}, rp};
                     seen_tab[count] = 1'b1;
                     count++;
                     all_bad = 1'b0;
                  end else begin
                     overflow = 1'b1;
                  end
               end
            end
            OP_CONNECT_FAILED: begin
               for (i = 0; i < count; i++)
                  if (addr_tab[i] == a)
                     prio_tab[i] = saturate(int'(prio_tab[i]) - int'(penalty));
            end
            OP_PICK: begin
               kept = 0;
               for (i = 0; i < count; i++) begin
                  if (seen_tab[i]) begin
                     addr_tab[kept] = addr_tab[i];
                     prio_tab[kept] = prio_tab[i];
                     seen_tab[kept] = 1'b1;
                     kept++;
                  end
               end
               count = kept;
               best = -1;
               chosen = '0;
               for (i = 0; i < count; i++) begin
                  if (int'(prio_tab[i]) >= best) begin
                     chosen = addr_tab[i];
                     best = int'(prio_tab[i]);
                  end else if (all_bad) begin
                     prio_tab[i] = saturate(int'(prio_tab[i]) + int'(penalty));
                  end
               end
               r.found = (best != -1);
               r.addr = chosen;
               r.prio = PRIO_W'(best);
               r.overflow = overflow;
               expected_picks.insert(expected_picks.size(), r);
            end
         endcase
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] d);
         pick_result_type want;
         if (expected_picks.size() == 0) begin
            note_mismatch("response with no pick waiting", 64'd0, d[63:0]);
            return;
         end
         want = expected_picks.pop_front();
         if (d[0] != want.found)
            note_mismatch("found", 64'(want.found), 64'(d[0]));
         if (d[48:1] != want.addr)
            note_mismatch("chosen_address", 64'(want.addr), 64'(d[48:1]));
         if (d[64:49] != want.prio[PRIO_W-1:0])
            note_mismatch("chosen_priority", 64'(want.prio[PRIO_W-1:0]), 64'(d[64:49]));
         if (d[65] != want.overflow)
            note_mismatch("overflow", 64'(want.overflow), 64'(d[65]));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pick_scoreboard    sb;
   bit                idle_on = 1'b1;
   int                sent = 0;
   int                stall_left = 0;
   logic [ADDR_W-1:0] pool[POOL_SIZE];

   failover_controller_picker dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
      if (stall_left != 0)
         stall_left--;
      else if (idle_on && $urandom_range(0, 9) == 0)
         stall_left = $urandom_range(1, 16);
      rsp_tready <= (stall_left == 0);
   end

   function automatic logic [ADDR_W-1:0] random_address();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   function automatic logic [RPRIO_W-1:0] random_priority();
      return RPRIO_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [ADDR_W-1:0] pool_address();
      if ($urandom_range(0, 9) == 0) return random_address();
      return pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   task automatic send(op_type op, logic [ADDR_W-1:0] a, logic [RPRIO_W-1:0] rp);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {rp, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, a, rp);
      sent++;
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_penalty(logic [PENALTY_W-1:0] value);
      wait_for_idle();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= REG_PENALTY;
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.penalty = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata != CSR_DATA_W'(value))
         sb.note_mismatch("penalty readback", 64'(value), 64'(csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_round();
      int sel;
      send(OP_START_ROUND, random_address(), random_priority());
      repeat ($urandom_range(0, 12)) begin
         sel = $urandom_range(0, 9);
         if (sel < 5)
            send(OP_REPORT, pool_address(), random_priority());
         else if (sel < 8)
            send(OP_CONNECT_FAILED, pool_address(), random_priority());
         else if (sel < 9)
            send(OP_PICK, random_address(), random_priority());
         else
            send(op_type'(REQ_USER_W'($urandom_range(0, 3))), pool_address(),
                 random_priority());
      end
      repeat ($urandom_range(1, 2)) send(OP_PICK, random_address(), random_priority());
   endtask

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [ADDR_W-1:0]    peer_a;
      logic [ADDR_W-1:0]    peer_b;
      logic [ADDR_W-1:0]    peer_p;
      logic [ADDR_W-1:0]    peer_q;
      logic [ADDR_W-1:0]    peer_r;
      logic [PENALTY_W-1:0] pen;
      int                   random_start;
      sb = new();
      peer_a = '1;
      peer_b = '0;
      peer_p = random_address();
      peer_q = random_address();
      peer_r = random_address();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A pick on the empty table, then a top-priority peer beating a penalized one.
      send(OP_PICK, peer_p, 8'd0);
      send(OP_START_ROUND, peer_a, 8'd255);
      send(OP_REPORT, peer_a, 8'd255);
      send(OP_REPORT, peer_b, 8'd0);
      send(OP_REPORT, peer_a, 8'd17);
      send(OP_CONNECT_FAILED, peer_b, 8'd255);
      send(OP_PICK, peer_b, 8'd0);
      // The unseen peer is dropped and the only survivor is negative.
      send(OP_START_ROUND, peer_b, 8'd0);
      send(OP_REPORT, peer_b, 8'd99);
      send(OP_PICK, peer_a, 8'd255);

      // Priorities of -1, -2 and -3 with a unit penalty.
      write_penalty(PENALTY_W'(1));
      send(OP_REPORT, peer_p, 8'd0);
      send(OP_REPORT, peer_q, 8'd0);
      send(OP_REPORT, peer_r, 8'd0);
      send(OP_CONNECT_FAILED, peer_p, 8'd0);
      repeat (2) send(OP_CONNECT_FAILED, peer_q, 8'd0);
      repeat (3) send(OP_CONNECT_FAILED, peer_r, 8'd0);

      // An all-bad round with the largest penalty: a choice at minus one, saturation at the
      // top, and a failure that takes a peer to the bottom of the range.
      write_penalty(PENALTY_W'(32767));
      send(OP_START_ROUND, random_address(), 8'd0);
      send(OP_REPORT, peer_p, 8'd0);
      send(OP_REPORT, peer_q, 8'd0);
      send(OP_REPORT, peer_r, 8'd0);
      repeat (3) send(OP_PICK, random_address(), 8'd0);
      send(OP_CONNECT_FAILED, peer_p, 8'd0);

      random_start = sent;
      for (int phase = 0; phase < PHASES; phase++) begin
         idle_on = (phase < PHASES - 1);
         case (phase)
            0: pen = PENALTY_W'(200);
            1: pen = '0;
            2: pen = PENALTY_W'(32767);
            3: pen = PENALTY_W'(1);
            5: pen = PENALTY_W'($urandom_range(1, 600));
            default: pen = PENALTY_W'($urandom_range(0, 32767));
         endcase
         write_penalty(pen);
         foreach (pool[i]) pool[i] = random_address();
         if (phase % 2 == 1) begin
            pool[0] = '0;
            pool[1] = '1;
         end
         while (sent < random_start + (phase + 1) * ITEM_GOAL / PHASES)
            run_round();
      end

      wait_for_idle();
      if (sb.errors == 0 && sb.expected_picks.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
